// File: hw/rtl/wdt_pkg.sv
// Package for the watchdog timer register block.
// Holds command codes, register offsets, reset values and the item structs.
// No dependencies.
`timescale 1ns / 1ps

package wdt_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [DATA_W-1:0] BASE_RESET = 32'h800B_0000;
    localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] LOCK_KEY   = 32'h1ACC_E551;

    localparam int unsigned CTL_IRQ_EN = 0;
    localparam int unsigned CTL_RST_EN = 1;

    localparam logic [DATA_W-1:0] OFF_LOAD   = 32'h000;
    localparam logic [DATA_W-1:0] OFF_VALUE  = 32'h004;
    localparam logic [DATA_W-1:0] OFF_CTRL   = 32'h008;
    localparam logic [DATA_W-1:0] OFF_INTCLR = 32'h00C;
    localparam logic [DATA_W-1:0] OFF_RAW    = 32'h010;
    localparam logic [DATA_W-1:0] OFF_MASKED = 32'h014;
    localparam logic [DATA_W-1:0] OFF_LOCK   = 32'hC00;
    localparam logic [DATA_W-1:0] OFF_ID0    = 32'hFE0;
    localparam logic [DATA_W-1:0] OFF_ID1    = 32'hFE4;
    localparam logic [DATA_W-1:0] OFF_ID2    = 32'hFE8;
    localparam logic [DATA_W-1:0] OFF_ID3    = 32'hFEC;
    localparam logic [DATA_W-1:0] OFF_ID4    = 32'hFF0;
    localparam logic [DATA_W-1:0] OFF_ID5    = 32'hFF4;
    localparam logic [DATA_W-1:0] OFF_ID6    = 32'hFF8;
    localparam logic [DATA_W-1:0] OFF_ID7    = 32'hFFC;

    localparam logic [7:0] ID0 = 8'h05;
    localparam logic [7:0] ID1 = 8'h18;
    localparam logic [7:0] ID2 = 8'h14;
    localparam logic [7:0] ID3 = 8'h00;
    localparam logic [7:0] ID4 = 8'h0D;
    localparam logic [7:0] ID5 = 8'hF0;
    localparam logic [7:0] ID6 = 8'h05;
    localparam logic [7:0] ID7 = 8'hB1;

    // item after the offset has been formed
    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_line;
        logic              reset_line;
    } t_result;

endpackage

// File: hw/rtl/wdt_if.sv
// Channel interfaces of the watchdog block: request, response, config write.
// No dependencies.
`timescale 1ns / 1ps

interface wdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] bus_addr;
    logic [31:0] write_data;

    modport source (output valid, output cmd, output bus_addr, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input bus_addr, input write_data,
                    output ready);
endinterface

interface wdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_line;
    logic        reset_line;

    modport source (output valid, output read_data, output irq_line,
                    output reset_line, input ready);
    modport sink   (input valid, input read_data, input irq_line,
                    input reset_line, output ready);
endinterface

interface wdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/wdt_in_stage.sv
// Input register of the watchdog block; holds the base address and forms
// the register offset on accept. Depends on wdt_pkg.
`timescale 1ns / 1ps

module wdt_in_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_cmd,
    input  logic [31:0]             i_bus_addr,
    input  logic [31:0]             i_write_data,
    input  logic                    i_cfg_valid,
    input  logic [31:0]             i_cfg_data,
    input  logic                    i_advance,
    output logic                    o_valid,
    output wdt_pkg::t_item          o_item
);

    logic                   r_valid;
    logic [31:0]            r_base;
    wdt_pkg::t_item         r_item;
    logic                   w_accept;

    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_base  <= wdt_pkg::BASE_RESET;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_advance) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
        end
    end

    // offset wraps modulo 2^32
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd    <= wdt_pkg::t_cmd'(i_cmd);
            r_item.offset <= i_bus_addr - r_base;
            r_item.data   <= i_write_data;
        end
    end

endmodule

// File: hw/rtl/wdt_core.sv
// Watchdog state and register logic: one item is applied per advance.
// Depends on wdt_pkg.
`timescale 1ns / 1ps

module wdt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  wdt_pkg::t_item      i_item,
    output wdt_pkg::t_result    o_result
);

    logic [31:0] r_load,     n_load;
    logic [31:0] r_cnt,      n_cnt;
    logic        r_counting, n_counting;
    logic [1:0]  r_ctl,      n_ctl;
    logic        r_locked,   n_locked;
    logic        r_raw,      n_raw;
    logic        r_mask,     n_mask;
    logic        r_rst,      n_rst;
    logic [31:0] w_rd;

    always_comb begin
        logic start_req;
        logic fire_req;
        logic halt;
        logic refresh;

        start_req  = 1'b0;
        fire_req   = 1'b0;
        halt       = 1'b0;
        refresh    = 1'b0;
        n_load     = r_load;
        n_cnt      = r_cnt;
        n_counting = r_counting;
        n_ctl      = r_ctl;
        n_locked   = r_locked;
        n_raw      = r_raw;
        n_mask     = r_mask;
        n_rst      = r_rst;
        w_rd       = '0;

        unique case (i_item.cmd)
            wdt_pkg::CMD_READ: begin
                unique case (i_item.offset)
                    wdt_pkg::OFF_LOAD:   w_rd = r_load;
                    wdt_pkg::OFF_VALUE:  w_rd = r_cnt;
                    wdt_pkg::OFF_CTRL:   w_rd = {30'd0, r_ctl};
                    wdt_pkg::OFF_RAW:    w_rd = {31'd0, r_raw};
                    wdt_pkg::OFF_MASKED: w_rd = {31'd0, r_mask};
                    wdt_pkg::OFF_LOCK:   w_rd = {31'd0, r_locked};
                    wdt_pkg::OFF_ID0:    w_rd = {24'd0, wdt_pkg::ID0};
                    wdt_pkg::OFF_ID1:    w_rd = {24'd0, wdt_pkg::ID1};
                    wdt_pkg::OFF_ID2:    w_rd = {24'd0, wdt_pkg::ID2};
                    wdt_pkg::OFF_ID3:    w_rd = {24'd0, wdt_pkg::ID3};
                    wdt_pkg::OFF_ID4:    w_rd = {24'd0, wdt_pkg::ID4};
                    wdt_pkg::OFF_ID5:    w_rd = {24'd0, wdt_pkg::ID5};
                    wdt_pkg::OFF_ID6:    w_rd = {24'd0, wdt_pkg::ID6};
                    wdt_pkg::OFF_ID7:    w_rd = {24'd0, wdt_pkg::ID7};
                    default:             w_rd = '0;
                endcase
            end
            wdt_pkg::CMD_WRITE: begin
                if (i_item.offset == wdt_pkg::OFF_LOCK) begin
                    n_locked = (i_item.data != wdt_pkg::LOCK_KEY);
                end else if (!r_locked) begin
                    unique case (i_item.offset)
                        wdt_pkg::OFF_LOAD: begin
                            n_load    = i_item.data;
                            start_req = r_ctl[wdt_pkg::CTL_IRQ_EN];
                        end
                        wdt_pkg::OFF_CTRL: begin
                            n_ctl   = i_item.data[1:0];
                            refresh = 1'b1;
                            if (!r_ctl[wdt_pkg::CTL_IRQ_EN]
                                    && i_item.data[wdt_pkg::CTL_IRQ_EN]) begin
                                start_req = 1'b1;
                            end else if (r_ctl[wdt_pkg::CTL_IRQ_EN]
                                    && !i_item.data[wdt_pkg::CTL_IRQ_EN]) begin
                                n_counting = 1'b0;
                            end
                        end
                        wdt_pkg::OFF_INTCLR: begin
                            n_raw     = 1'b0;
                            n_mask    = 1'b0;
                            start_req = r_ctl[wdt_pkg::CTL_IRQ_EN];
                        end
                        default: ;
                    endcase
                end
            end
            wdt_pkg::CMD_TICK: begin
                if (r_counting) begin
                    // a count of one or zero expires on this tick
                    if (r_cnt[31:1] == '0) begin
                        n_cnt    = r_load;
                        fire_req = 1'b1;
                        halt     = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 32'd1;
                    end
                end
            end
            wdt_pkg::CMD_NOP: ;
            default: ;
        endcase

        // zero load fires at once and leaves the counter alone
        if (start_req) begin
            if (n_load == '0) begin
                fire_req = 1'b1;
            end else begin
                n_cnt      = n_load;
                n_counting = 1'b1;
            end
        end

        if (fire_req) begin
            if (n_raw) begin
                if (n_ctl[wdt_pkg::CTL_RST_EN]) begin
                    n_rst = 1'b1;
                end
                if (halt) begin
                    n_counting = 1'b0;
                end
            end else begin
                n_raw  = 1'b1;
                n_mask = n_ctl[wdt_pkg::CTL_IRQ_EN];
            end
        end

        if (refresh) begin
            n_mask = n_raw && n_ctl[wdt_pkg::CTL_IRQ_EN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load     <= wdt_pkg::ALL_ONES;
            r_cnt      <= wdt_pkg::ALL_ONES;
            r_counting <= 1'b0;
            r_ctl      <= '0;
            r_locked   <= 1'b0;
            r_raw      <= 1'b0;
            r_mask     <= 1'b0;
            r_rst      <= 1'b0;
        end else if (i_advance) begin
            r_load     <= n_load;
            r_cnt      <= n_cnt;
            r_counting <= n_counting;
            r_ctl      <= n_ctl;
            r_locked   <= n_locked;
            r_raw      <= n_raw;
            r_mask     <= n_mask;
            r_rst      <= n_rst;
        end
    end

    assign o_result.read_data  = w_rd;
    assign o_result.irq_line   = n_mask;
    assign o_result.reset_line = n_rst;

endmodule

// File: hw/rtl/wdt_out_reg.sv
// Result register of the watchdog block; holds an item until taken.
// Depends on wdt_pkg.
`timescale 1ns / 1ps

module wdt_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  wdt_pkg::t_result    i_result,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output wdt_pkg::t_result    o_result
);

    logic              r_valid;
    wdt_pkg::t_result  r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hw/rtl/watchdog_timer_registers.sv
// Top level of the watchdog timer register block.
// Depends on wdt_pkg, wdt_if, wdt_in_stage, wdt_core, wdt_out_reg.
//
//   channel  dir  payload                          accepted when
//   i_req    in   cmd, bus_addr, write_data        valid && ready
//   o_rsp    out  read_data, irq_line, reset_line  valid && ready
//   i_cfg    in   data (base address)              valid && ready (ready tied high)
//
// Every item gives one result: the input register holds it (offset formed),
// then the register/counter logic loads the result register. One item per
// cycle sustained while results are taken; a stalled result register holds the
// input register, which still takes one more item. Synchronous active-low reset
// clears valid flags and watchdog state, sets the base; data regs are not reset.
`timescale 1ns / 1ps

module watchdog_timer_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wdt_req_if.sink    i_req,
    wdt_rsp_if.source  o_rsp,
    wdt_cfg_if.sink    i_cfg
);

    logic              w_in_valid;
    logic              w_can_load;
    logic              w_advance;
    wdt_pkg::t_item    w_item;
    wdt_pkg::t_result  w_result;
    wdt_pkg::t_result  w_out;

    assign w_advance   = w_in_valid && w_can_load;
    assign i_cfg.ready = 1'b1;

    wdt_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_cmd        (i_req.cmd),
        .i_bus_addr   (i_req.bus_addr),
        .i_write_data (i_req.write_data),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .i_advance    (w_advance),
        .o_valid      (w_in_valid),
        .o_item       (w_item)
    );

    wdt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .o_result  (w_result)
    );

    wdt_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_valid    (o_rsp.valid),
        .i_ready    (o_rsp.ready),
        .o_result   (w_out)
    );

    assign o_rsp.read_data  = w_out.read_data;
    assign o_rsp.irq_line   = w_out.irq_line;
    assign o_rsp.reset_line = w_out.reset_line;

endmodule

// File: hw/rtl/wdt_checker.sv
// Port-level checks on the watchdog top level, attached with bind.
// Depends on the port list of watchdog_timer_registers.
`timescale 1ns / 1ps

module wdt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_read_data,
    input  logic        i_rsp_irq_line,
    input  logic        i_rsp_reset_line
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_inflight;
    logic       r_rst_seen;

    assign w_in_acc  = i_req_valid && i_req_ready;
    assign w_out_acc = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_rst_seen <= 1'b0;
        end else begin
            r_inflight <= r_inflight + {1'b0, w_in_acc} - {1'b0, w_out_acc};
            if (w_out_acc && i_rsp_reset_line) begin
                r_rst_seen <= 1'b1;
            end
        end
    end

    // no result without an item in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_inflight != 2'd0)
        else $error("result shown with no item in flight");

    // at most two items held: input and result registers
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 2'd2) |-> !i_req_ready || w_out_acc)
        else $error("input taken while both stages are full");

    // latched watchdog reset never drops
    a_rst_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_rst_seen) |-> i_rsp_reset_line)
        else $error("reset_line fell after being reported");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            i_rsp_valid && $stable(i_rsp_read_data) && $stable(i_rsp_irq_line)
            && $stable(i_rsp_reset_line))
        else $error("stalled result changed");

endmodule

bind watchdog_timer_registers wdt_checker u_wdt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_read_data  (o_rsp.read_data),
    .i_rsp_irq_line   (o_rsp.irq_line),
    .i_rsp_reset_line (o_rsp.reset_line)
);
